@@ src/rgba8_pixel_format_packer_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RGBA8_PIXEL_FORMAT_PACKER_DEFINES_SVH
`define RGBA8_PIXEL_FORMAT_PACKER_DEFINES_SVH

// Checked only outside reset.
`define RFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rfp_pkg.sv @@
`default_nettype none

package rfp_pkg;

  // Output format codes (out_format register).
  typedef enum logic [3:0] {
    FMT_ABGR     = 4'd0,
    FMT_BGR      = 4'd1,
    FMT_BGR_BLUE = 4'd2,
    FMT_RGB_BLUE = 4'd3,
    FMT_BGRA     = 4'd4,
    FMT_4444     = 4'd5,
    FMT_5551     = 4'd6,
    FMT_BGR565   = 4'd7,
    FMT_RGB565   = 4'd8,
    FMT_UV88     = 4'd9,
    FMT_UVWQ     = 4'd10,
    FMT_RGBA16   = 4'd11,
    FMT_COPY     = 4'd12
  } fmt_e;

  // Copy-mode channel layouts (src_layout register).
  typedef enum logic [2:0] {
    LAY_RGBA = 3'd0,
    LAY_RGB  = 3'd1,
    LAY_RA   = 3'd2,
    LAY_R    = 3'd3,
    LAY_A    = 3'd4
  } layout_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_OUT_FORMAT      = 2'd0,
    CFG_SRC_LAYOUT      = 2'd1,
    CFG_ALPHA_THRESHOLD = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [3:0] OutFormatRst      = FMT_BGRA;
  localparam logic [2:0] SrcLayoutRst      = LAY_RGBA;
  localparam logic [8:0] AlphaThresholdRst = 9'd128;

  localparam logic [7:0] KeyBlue   = 8'd255;
  localparam logic [7:0] NudgeBlue = 8'd254;

  // Stage 1 -> stage 2 payload.
  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [7:0]  kr;   // blue-screen keyed channels
    logic [7:0]  kg;
    logic [7:0]  kb;
    logic [14:0] pr;   // 127 * channel
    logic [14:0] pg;
    logic [14:0] pb;
    logic [14:0] pa;
    logic        last;
  } s1_t;

  // Stage 2 -> output payload.
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
  } s2_t;

  // Active configuration.
  typedef struct packed {
    logic [3:0] out_format;
    logic [2:0] src_layout;
    logic [8:0] alpha_threshold;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/rfp_prep.sv @@
`default_nettype none

// Stage 1: blue-screen nudge/key and 127*x products for UV scaling.
module rfp_prep (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        valid_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic [7:0]  alpha_i,
  input  wire logic        last_i,
  input  wire logic [8:0]  alpha_threshold_i,
  output logic             valid_o,
  output rfp_pkg::s1_t     data_o
);

  logic         valid_q, valid_d;
  rfp_pkg::s1_t data_q, data_d;

  function automatic logic [14:0] times127(input logic [7:0] x);
    return ({x, 7'b0}) - {7'b0, x};
  endfunction

  always_comb begin
    data_d      = data_q;
    valid_d     = valid_q;
    if (load_i) begin
      valid_d     = valid_i;
      data_d.r    = red_i;
      data_d.g    = green_i;
      data_d.b    = blue_i;
      data_d.a    = alpha_i;
      data_d.last = last_i;
      data_d.kr   = red_i;
      data_d.kg   = green_i;
      data_d.kb   = blue_i;
      // keep real pure blue from reading as the key
      if (red_i == 8'd0 && green_i == 8'd0 && blue_i == rfp_pkg::KeyBlue) begin
        data_d.kb = rfp_pkg::NudgeBlue;
      end
      if ({1'b0, alpha_i} < alpha_threshold_i) begin
        data_d.kr = 8'd0;
        data_d.kg = 8'd0;
        data_d.kb = rfp_pkg::KeyBlue;
      end
      data_d.pr = times127(red_i);
      data_d.pg = times127(green_i);
      data_d.pb = times127(blue_i);
      data_d.pa = times127(alpha_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ src/rfp_pack.sv @@
`default_nettype none

// Stage 2: divide-by-255 finish for UV and format byte packing.
module rfp_pack (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        valid_i,
  input  wire rfp_pkg::s1_t data_i,
  input  wire logic [3:0]  out_format_i,
  input  wire logic [2:0]  src_layout_i,
  output logic             valid_o,
  output rfp_pkg::s2_t     data_o
);

  logic         valid_q, valid_d;
  rfp_pkg::s2_t data_q, data_d;
  logic [7:0]   ur, ug, ub, ua;
  logic [63:0]  bytes;
  logic [3:0]   count;

  // floor(p/255) for any 15-bit p
  function automatic logic [7:0] div255(input logic [14:0] p);
    logic [15:0] s;
    s = {1'b0, p} + {9'b0, p[14:8]} + 16'd1;
    return s[15:8];
  endfunction

  always_comb begin
    ur = div255(data_i.pr);
    ug = div255(data_i.pg);
    ub = div255(data_i.pb);
    ua = div255(data_i.pa);
  end

  always_comb begin
    bytes = 64'd0;
    count = 4'd0;
    case (rfp_pkg::fmt_e'(out_format_i))
      rfp_pkg::FMT_ABGR: begin
        bytes = {32'd0, data_i.r, data_i.g, data_i.b, data_i.a};
        count = 4'd4;
      end
      rfp_pkg::FMT_BGR: begin
        bytes = {40'd0, data_i.r, data_i.g, data_i.b};
        count = 4'd3;
      end
      rfp_pkg::FMT_BGR_BLUE: begin
        bytes = {40'd0, data_i.kr, data_i.kg, data_i.kb};
        count = 4'd3;
      end
      rfp_pkg::FMT_RGB_BLUE: begin
        bytes = {40'd0, data_i.kb, data_i.kg, data_i.kr};
        count = 4'd3;
      end
      rfp_pkg::FMT_BGRA: begin
        bytes = {32'd0, data_i.a, data_i.r, data_i.g, data_i.b};
        count = 4'd4;
      end
      rfp_pkg::FMT_4444: begin
        bytes = {48'd0, data_i.a[7:4], data_i.r[7:4], data_i.g[7:4], data_i.b[7:4]};
        count = 4'd2;
      end
      rfp_pkg::FMT_5551: begin
        bytes = {48'd0, data_i.a[7], data_i.r[7:3], data_i.g[7:3], data_i.b[7:3]};
        count = 4'd2;
      end
      rfp_pkg::FMT_BGR565: begin
        bytes = {48'd0, data_i.r[7:3], data_i.g[7:2], data_i.b[7:3]};
        count = 4'd2;
      end
      rfp_pkg::FMT_RGB565: begin
        bytes = {48'd0, data_i.b[7:3], data_i.g[7:2], data_i.r[7:3]};
        count = 4'd2;
      end
      rfp_pkg::FMT_UV88: begin
        bytes = {48'd0, ug, ur};
        count = 4'd2;
      end
      rfp_pkg::FMT_UVWQ: begin
        bytes = {32'd0, ua, ub, ug, ur};
        count = 4'd4;
      end
      rfp_pkg::FMT_RGBA16: begin
        // x*257 puts x in both bytes of each word
        bytes = {data_i.a, data_i.a, data_i.b, data_i.b,
                 data_i.g, data_i.g, data_i.r, data_i.r};
        count = 4'd8;
      end
      rfp_pkg::FMT_COPY: begin
        case (rfp_pkg::layout_e'(src_layout_i))
          rfp_pkg::LAY_RGBA: begin
            bytes = {32'd0, data_i.a, data_i.b, data_i.g, data_i.r};
            count = 4'd4;
          end
          rfp_pkg::LAY_RGB: begin
            bytes = {40'd0, data_i.b, data_i.g, data_i.r};
            count = 4'd3;
          end
          rfp_pkg::LAY_RA: begin
            bytes = {48'd0, data_i.a, data_i.r};
            count = 4'd2;
          end
          rfp_pkg::LAY_R: begin
            bytes = {56'd0, data_i.r};
            count = 4'd1;
          end
          rfp_pkg::LAY_A: begin
            bytes = {56'd0, data_i.a};
            count = 4'd1;
          end
          default: begin
            bytes = 64'd0;
            count = 4'd0;
          end
        endcase
      end
      default: begin
        bytes = 64'd0;
        count = 4'd0;
      end
    endcase
  end

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (load_i) begin
      valid_d      = valid_i;
      data_d.bytes = bytes;
      data_d.count = count;
      data_d.last  = data_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ src/rgba8_pixel_format_packer.sv @@
// A pixel request passes three registers (prep, pack, output register) to output valid.
// Throughput: one pixel request per cycle unless in_stall_o; each stage holds or advances
//   on its own, so bubbles collapse and a stalled output leaves two stages free to fill.
// Reset (rst_ni, async, active low): all stage valids clear, configuration returns
//   to out_format BGRA, src_layout RGBA, alpha_threshold 128.
`default_nettype none

module rgba8_pixel_format_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pixel input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic [7:0]  alpha_i,
  input  wire logic        last_in_i,
  // packed output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      packed_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             last_out_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [rfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rfp_pkg::CfgDataW-1:0] cfg_data_i
);

  // ------------------------------------------------------------------
  // Configuration registers. Always ready; writes to unused indexes drop.
  // ------------------------------------------------------------------
  rfp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (rfp_pkg::cfg_idx_e'(cfg_index_i))
        rfp_pkg::CFG_OUT_FORMAT:      cfg_d.out_format      = cfg_data_i[3:0];
        rfp_pkg::CFG_SRC_LAYOUT:      cfg_d.src_layout      = cfg_data_i[2:0];
        rfp_pkg::CFG_ALPHA_THRESHOLD: cfg_d.alpha_threshold = cfg_data_i[8:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_format      <= rfp_pkg::OutFormatRst;
      cfg_q.src_layout      <= rfp_pkg::SrcLayoutRst;
      cfg_q.alpha_threshold <= rfp_pkg::AlphaThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ------------------------------------------------------------------
  // Per-stage ready: a stage loads when it is empty or its contents move on.
  // ------------------------------------------------------------------
  logic         s1_valid, s2_valid;
  rfp_pkg::s1_t s1_data;
  rfp_pkg::s2_t s2_data;
  logic         s1_load, s2_load, s3_load;

  logic         out_valid_q, out_valid_d;
  rfp_pkg::s2_t out_data_q, out_data_d;

  assign s3_load    = !out_valid_q || !out_stall_i;
  assign s2_load    = !s2_valid || s3_load;
  assign s1_load    = !s1_valid || s2_load;
  assign in_stall_o = !s1_load;

  // Stage 1: keying and UV products
  rfp_prep u_prep (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (s1_load),
    .valid_i           (in_valid_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .alpha_i           (alpha_i),
    .last_i            (last_in_i),
    .alpha_threshold_i (cfg_q.alpha_threshold),
    .valid_o           (s1_valid),
    .data_o            (s1_data)
  );

  // Stage 2: byte packing per format
  rfp_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (s2_load),
    .valid_i      (s1_valid),
    .data_i       (s1_data),
    .out_format_i (cfg_q.out_format),
    .src_layout_i (cfg_q.src_layout),
    .valid_o      (s2_valid),
    .data_o       (s2_data)
  );

  // Stage 3: output register, holds while the consumer stalls
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s3_load) begin
      out_valid_d = s2_valid;
      out_data_d  = s2_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign packed_bytes_o = out_data_q.bytes;
  assign byte_count_o   = out_data_q.count;
  assign last_out_o     = out_data_q.last;

endmodule

`default_nettype wire

@@ src/rfp_checker.sv @@
`default_nettype none
`include "rgba8_pixel_format_packer_defines.svh"

module rfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] packed_bytes_o,
  input wire logic [3:0]  byte_count_o,
  input wire logic        last_out_o
);

  // input may only back up when the output is full and stalled
  property p_stall_src;
    in_stall_o |-> (out_valid_o && out_stall_i);
  endproperty

  // a stalled result holds
  property p_out_hold;
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(packed_bytes_o) && $stable(byte_count_o) &&
       $stable(last_out_o));
  endproperty

  // count in range and unused bytes zero for an empty result
  property p_count_ok;
    out_valid_o |->
      (byte_count_o <= 4'd8 && (byte_count_o != 4'd0 || packed_bytes_o == 64'd0));
  endproperty

  // nothing comes out in the cycle after a reset edge
  `RFP_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "output valid after reset")

  `RFP_ASSERT(a_stall_src, clk_i, rst_ni, p_stall_src, "input stall without output stall")

  `RFP_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled result changed")

  `RFP_ASSERT(a_count_ok, clk_i, rst_ni, p_count_ok, "bad byte count or stray bytes")

endmodule

bind rgba8_pixel_format_packer rfp_checker u_rfp_checker (.*);

`default_nettype wire

@@ tb/tb_rgba8_pixel_format_packer.sv @@
`timescale 1ns / 1ps

module tb_rgba8_pixel_format_packer;

  // Codes outside the enums: the block must answer them with an empty result.
  localparam logic [3:0] FmtUnused = 4'd15;
  localparam logic [2:0] LayUnused = 3'd7;

  // Watchdog.
  localparam int unsigned RunLimit = 200000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic [7:0]  alpha_i = '0;
  logic        last_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] packed_bytes_o;
  logic [3:0]  byte_count_o;
  logic        last_out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [rfp_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [rfp_pkg::CfgDataW-1:0] cfg_data_i = '0;

  rgba8_pixel_format_packer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .last_in_i      (last_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_bytes_o (packed_bytes_o),
    .byte_count_o   (byte_count_o),
    .last_out_o     (last_out_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Directed pixel: register setting, channels, and optionally a hand-worked result.
  typedef struct packed {
    logic [3:0]  fmt;
    logic [2:0]  lay;
    logic [8:0]  thr;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last;
    logic        known;   // 1: bytes/cnt below are the answer, 0: ask the predictor
    logic [63:0] bytes;
    logic [3:0]  cnt;
  } px_row_t;

  // Register setting changes only between groups; rows are ordered to keep writes few.
  px_row_t dir_rows [26] = '{
    // reset setting (BGRA) untouched
    '{rfp_pkg::FMT_BGRA, rfp_pkg::LAY_RGBA, 9'd128,
      8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 64'h44112233, 4'd4},
    '{rfp_pkg::FMT_ABGR, rfp_pkg::LAY_RGBA, 9'd128,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 64'hFFFFFFFF, 4'd4},
    '{rfp_pkg::FMT_BGR, rfp_pkg::LAY_RGBA, 9'd128,
      8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 64'h0, 4'd3},
    // pure blue nudged off the key
    '{rfp_pkg::FMT_BGR_BLUE, rfp_pkg::LAY_RGBA, 9'd128,
      8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 64'hFE, 4'd3},
    // alpha just under threshold -> key
    '{rfp_pkg::FMT_BGR_BLUE, rfp_pkg::LAY_RGBA, 9'd128,
      8'h55, 8'h55, 8'h55, 8'h7F, 1'b0, 1'b1, 64'hFF, 4'd3},
    // alpha equal to threshold -> kept
    '{rfp_pkg::FMT_BGR_BLUE, rfp_pkg::LAY_RGBA, 9'd128,
      8'h10, 8'h20, 8'h30, 8'h80, 1'b0, 1'b1, 64'h102030, 4'd3},
    // threshold 0 never keys
    '{rfp_pkg::FMT_BGR_BLUE, rfp_pkg::LAY_RGBA, 9'd0,
      8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 64'hFE, 4'd3},
    // threshold above any alpha keys everything
    '{rfp_pkg::FMT_RGB_BLUE, rfp_pkg::LAY_RGBA, 9'd256,
      8'h12, 8'h34, 8'h56, 8'hFF, 1'b0, 1'b1, 64'hFF0000, 4'd3},
    '{rfp_pkg::FMT_RGB_BLUE, rfp_pkg::LAY_RGBA, 9'd1,
      8'h00, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 64'hFF0000, 4'd3},
    '{rfp_pkg::FMT_RGB_BLUE, rfp_pkg::LAY_RGBA, 9'd255,
      8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 64'hFE0000, 4'd3},
    '{rfp_pkg::FMT_4444, rfp_pkg::LAY_RGBA, 9'd255,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 64'hFFFF, 4'd2},
    '{rfp_pkg::FMT_4444, rfp_pkg::LAY_RGBA, 9'd255,
      8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 1'b0, 64'h0, 4'd0},
    '{rfp_pkg::FMT_5551, rfp_pkg::LAY_RGBA, 9'd255,
      8'h00, 8'h00, 8'h00, 8'h80, 1'b0, 1'b1, 64'h8000, 4'd2},
    '{rfp_pkg::FMT_5551, rfp_pkg::LAY_RGBA, 9'd255,
      8'h7F, 8'h81, 8'hC3, 8'h7F, 1'b0, 1'b0, 64'h0, 4'd0},
    '{rfp_pkg::FMT_BGR565, rfp_pkg::LAY_RGBA, 9'd255,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 64'hFFFF, 4'd2},
    '{rfp_pkg::FMT_RGB565, rfp_pkg::LAY_RGBA, 9'd255,
      8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 64'h1F, 4'd2},
    '{rfp_pkg::FMT_UV88, rfp_pkg::LAY_RGBA, 9'd255,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 64'h7F7F, 4'd2},
    '{rfp_pkg::FMT_UVWQ, rfp_pkg::LAY_RGBA, 9'd255,
      8'h80, 8'h01, 8'hFE, 8'h40, 1'b1, 1'b0, 64'h0, 4'd0},
    '{rfp_pkg::FMT_RGBA16, rfp_pkg::LAY_RGBA, 9'd255,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '1, 4'd8},
    '{rfp_pkg::FMT_COPY, rfp_pkg::LAY_RGBA, 9'd255,
      8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 64'h44332211, 4'd4},
    '{rfp_pkg::FMT_COPY, rfp_pkg::LAY_RGB, 9'd255,
      8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 64'h332211, 4'd3},
    '{rfp_pkg::FMT_COPY, rfp_pkg::LAY_RA, 9'd255,
      8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 64'h4411, 4'd2},
    '{rfp_pkg::FMT_COPY, rfp_pkg::LAY_R, 9'd255,
      8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 64'h11, 4'd1},
    '{rfp_pkg::FMT_COPY, rfp_pkg::LAY_A, 9'd255,
      8'h11, 8'h22, 8'h33, 8'h44, 1'b0, 1'b1, 64'h44, 4'd1},
    // unknown layout / unknown format: empty result, last still passed through
    '{rfp_pkg::FMT_COPY, LayUnused, 9'd255,
      8'hAA, 8'hBB, 8'hCC, 8'hDD, 1'b1, 1'b1, 64'h0, 4'd0},
    '{FmtUnused, LayUnused, 9'd255,
      8'hAA, 8'hBB, 8'hCC, 8'hDD, 1'b1, 1'b1, 64'h0, 4'd0}
  };

  // Register setting as the block holds it (mirrors every accepted write).
  logic [3:0] cur_fmt       = rfp_pkg::OutFormatRst;
  logic [2:0] cur_layout    = rfp_pkg::SrcLayoutRst;
  logic [8:0] cur_threshold = rfp_pkg::AlphaThresholdRst;

  rfp_pkg::s2_t packed_due [$];  // results owed by the block, oldest first
  bit          failed = 1'b0;
  int          tx_idle_pct;      // chance (%) the pixel source idles before a pixel
  int          rx_idle_pct;      // chance (%) the sink stalls a cycle
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sink back-pressure, independent of anything the block shows.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // floor(127 * x / 255), exact in 16 bits
  function automatic logic [7:0] scale_to_uv(logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd127;
    return 8'(p / 16'd255);
  endfunction

  // Packed form of one pixel under the current register setting.
  function automatic rfp_pkg::s2_t pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                              logic [7:0] a, logic last);
    logic [7:0]   seq [8];
    logic [7:0]   kr, kg, kb;
    int           n;
    rfp_pkg::s2_t res;
    n  = 0;
    kr = r;
    kg = g;
    kb = b;
    case (cur_fmt)
      rfp_pkg::FMT_ABGR: begin
        seq[0] = a; seq[1] = b; seq[2] = g; seq[3] = r; n = 4;
      end
      rfp_pkg::FMT_BGR: begin
        seq[0] = b; seq[1] = g; seq[2] = r; n = 3;
      end
      rfp_pkg::FMT_BGR_BLUE, rfp_pkg::FMT_RGB_BLUE: begin
        // real pure blue must not read back as the key color
        if (r == 8'd0 && g == 8'd0 && b == rfp_pkg::KeyBlue) kb = rfp_pkg::NudgeBlue;
        if ({1'b0, a} < cur_threshold) begin
          kr = 8'd0; kg = 8'd0; kb = rfp_pkg::KeyBlue;
        end
        if (cur_fmt == rfp_pkg::FMT_BGR_BLUE) begin
          seq[0] = kb; seq[1] = kg; seq[2] = kr;
        end else begin
          seq[0] = kr; seq[1] = kg; seq[2] = kb;
        end
        n = 3;
      end
      rfp_pkg::FMT_BGRA: begin
        seq[0] = b; seq[1] = g; seq[2] = r; seq[3] = a; n = 4;
      end
      // 16-bit words go out low byte first
      rfp_pkg::FMT_4444: begin
        {seq[1], seq[0]} = {a[7:4], r[7:4], g[7:4], b[7:4]}; n = 2;
      end
      rfp_pkg::FMT_5551: begin
        {seq[1], seq[0]} = {a[7], r[7:3], g[7:3], b[7:3]}; n = 2;
      end
      rfp_pkg::FMT_BGR565: begin
        {seq[1], seq[0]} = {r[7:3], g[7:2], b[7:3]}; n = 2;
      end
      rfp_pkg::FMT_RGB565: begin
        {seq[1], seq[0]} = {b[7:3], g[7:2], r[7:3]}; n = 2;
      end
      rfp_pkg::FMT_UV88: begin
        seq[0] = scale_to_uv(r); seq[1] = scale_to_uv(g); n = 2;
      end
      rfp_pkg::FMT_UVWQ: begin
        seq[0] = scale_to_uv(r); seq[1] = scale_to_uv(g);
        seq[2] = scale_to_uv(b); seq[3] = scale_to_uv(a); n = 4;
      end
      rfp_pkg::FMT_RGBA16: begin
        // x * 257 is x repeated in both bytes
        seq[0] = r; seq[1] = r; seq[2] = g; seq[3] = g;
        seq[4] = b; seq[5] = b; seq[6] = a; seq[7] = a; n = 8;
      end
      rfp_pkg::FMT_COPY: begin
        case (cur_layout)
          rfp_pkg::LAY_RGBA: begin
            seq[0] = r; seq[1] = g; seq[2] = b; seq[3] = a; n = 4;
          end
          rfp_pkg::LAY_RGB: begin
            seq[0] = r; seq[1] = g; seq[2] = b; n = 3;
          end
          rfp_pkg::LAY_RA: begin
            seq[0] = r; seq[1] = a; n = 2;
          end
          rfp_pkg::LAY_R: begin
            seq[0] = r; n = 1;
          end
          rfp_pkg::LAY_A: begin
            seq[0] = a; n = 1;
          end
          default: n = 0;
        endcase
      end
      default: n = 0;
    endcase
    res.bytes = '0;
    for (int i = 0; i < n; i++) res.bytes[8*i +: 8] = seq[i];
    res.count = 4'(n);
    res.last  = last;
    return res;
  endfunction

  // One register write request; valid then drops before the task returns.
  task automatic write_reg(rfp_pkg::cfg_idx_e idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, let the pipe run dry, then write whatever differs.
  task automatic apply_setup(logic [3:0] fmt, logic [2:0] lay, logic [8:0] thr);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (packed_due.size() != 0) @(posedge clk_i);
    if (fmt != cur_fmt) begin
      write_reg(rfp_pkg::CFG_OUT_FORMAT, 9'(fmt));
      cur_fmt = fmt;
    end
    if (lay != cur_layout) begin
      write_reg(rfp_pkg::CFG_SRC_LAYOUT, 9'(lay));
      cur_layout = lay;
    end
    if (thr != cur_threshold) begin
      write_reg(rfp_pkg::CFG_ALPHA_THRESHOLD, thr);
      cur_threshold = thr;
    end
  endtask

  // One pixel request, with an optional idle gap in front. Payload holds until accepted.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                            logic last, bit known, rfp_pkg::s2_t known_res);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    alpha_i    <= a;
    last_in_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    packed_due.push_back(known ? known_res : pack_pixel(r, g, b, a, last));
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Output side: every accepted result against the oldest owed one.
  always @(posedge clk_i) begin : result_check
    rfp_pkg::s2_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (packed_due.size() == 0) begin
        $display("%0t: result with nothing owed: bytes %h count %0d last %b",
                 $time, packed_bytes_o, byte_count_o, last_out_o);
        failed = 1'b1;
      end else begin
        want = packed_due.pop_front();
        if (packed_bytes_o !== want.bytes) begin
          $display("%0t: packed_bytes expected %h got %h", $time, want.bytes, packed_bytes_o);
          failed = 1'b1;
        end
        if (byte_count_o !== want.count) begin
          $display("%0t: byte_count expected %0d got %0d", $time, want.count, byte_count_o);
          failed = 1'b1;
        end
        if (last_out_o !== want.last) begin
          $display("%0t: last_out expected %b got %b", $time, want.last, last_out_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0]   r, g, b, a;
    logic         last;
    logic [3:0]   fmt;
    logic [2:0]   lay;
    logic [8:0]   thr;
    int           t;
    rfp_pkg::s2_t typed_res;

    // idle mix A: source rarely idles, sink stalls often
    tx_idle_pct = 6;
    rx_idle_pct = 58;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; the first one runs on the reset setting.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != cur_fmt || dir_rows[i].lay != cur_layout ||
          dir_rows[i].thr != cur_threshold) begin
        apply_setup(dir_rows[i].fmt, dir_rows[i].lay, dir_rows[i].thr);
      end
      typed_res = '{dir_rows[i].bytes, dir_rows[i].cnt, dir_rows[i].last};
      send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].a,
                 dir_rows[i].last, dir_rows[i].known, typed_res);
    end

    // Random groups of 25 pixels, each on a fresh random register setting.
    for (int c = 0; c < 26; c++) begin
      if (c == 9) begin
        // idle mix B: the other way round
        tx_idle_pct = 58;
        rx_idle_pct = 6;
      end
      if (c == 18) begin
        // full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if ($urandom_range(9) == 0) fmt = 4'($urandom_range(15, 13));
      else if ($urandom_range(3) == 0) fmt = rfp_pkg::FMT_COPY;
      else fmt = 4'($urandom_range(12));
      lay = ($urandom_range(3) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(4))
          0:       thr = 9'd0;
          1:       thr = 9'd1;
          2:       thr = 9'd255;
          3:       thr = 9'd256;
          default: thr = 9'd511;
        endcase
      end else begin
        thr = 9'($urandom_range(511));
      end
      apply_setup(fmt, lay, thr);

      for (int i = 0; i < 25; i++) begin
        // mid-group hold-off: source waits until every owed result is out
        if (c == 3 && i == 12) apply_setup(cur_fmt, cur_layout, cur_threshold);
        r = rand_channel();
        g = rand_channel();
        b = rand_channel();
        a = rand_channel();
        // aim at the blue-screen corners: pure blue, alpha around the threshold
        if ((cur_fmt == rfp_pkg::FMT_BGR_BLUE || cur_fmt == rfp_pkg::FMT_RGB_BLUE) &&
            $urandom_range(4) == 0) begin
          r = 8'd0;
          g = 8'd0;
          b = rfp_pkg::KeyBlue;
        end
        if ($urandom_range(3) == 0) begin
          t = int'(cur_threshold) + int'($urandom_range(2)) - 1;
          a = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
        end
        last = ($urandom_range(7) == 0);
        send_pixel(r, g, b, a, last, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (packed_due.size() != 0) @(posedge clk_i);
    // wait on to catch anything extra the block might emit
    repeat (8) @(posedge clk_i);

    if (!failed && packed_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
